>>> rtl/core/bmprle_pkg.sv
// Shared types and constants for the bitmap RLE decoder.
`timescale 1ns / 1ps

package bmprle_pkg;

  // Saturation limits for the image size registers
  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  // Nibble mask for 4-bit pixel values
  localparam logic [7:0] NIB_MASK = 8'h0f;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_NIBBLE_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_TOP_DOWN     = 2'd3
  } reg_idx_t;

  // Decoder phases
  typedef enum logic [2:0] {
    PH_CMD0 = 3'd0,
    PH_CMD1 = 3'd1,
    PH_LIT  = 3'd2,
    PH_PAD  = 3'd3,
    PH_DX   = 3'd4,
    PH_DY   = 3'd5
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SPAN = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // One queue entry: an optional span followed by an optional report
  typedef struct packed {
    logic        has_span;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  span_length;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic        has_report;
    kind_t       report_kind;
  } entry_t;

endpackage

>>> rtl/core/bmprle_front.sv
// Front end: takes compressed bytes, tracks the cursor and builds result entries.
`timescale 1ns / 1ps

module bmprle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_wdata,
  // input beat
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  // entry toward the queue
  output logic                 push,
  output bmprle_pkg::entry_t   push_entry
);

  // configuration registers
  logic        nibble_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic        top_down_r;

  // decoding state
  bmprle_pkg::phase_t phase_r, phase_nxt;
  logic [12:0] cx_r, cx_nxt;
  logic [12:0] cy_r, cy_nxt;
  logic [7:0]  lit_left_r, lit_left_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        pad_r, pad_nxt;
  logic        drain_r, drain_nxt;

  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic        y_bad;
  logic [13:0] run_end;
  logic [13:0] lit_end;
  logic [13:0] dx_sum;
  logic [13:0] dy_sum;
  logic [12:0] flip_row;
  logic [7:0]  lit_len;
  logic        clear;
  bmprle_pkg::entry_t ent;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_r   <= 1'b0;
      width_r    <= 13'd1;
      height_r   <= 13'd1;
      top_down_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmprle_pkg::REG_NIBBLE_MODE:  nibble_r   <= cfg_wdata[0];
        bmprle_pkg::REG_IMAGE_WIDTH:  width_r    <= cfg_wdata;
        bmprle_pkg::REG_IMAGE_HEIGHT: height_r   <= cfg_wdata;
        bmprle_pkg::REG_TOP_DOWN:     top_down_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturate the image size and form the range checks
  assign w_eff    = (width_r > bmprle_pkg::MAX_WIDTH) ? bmprle_pkg::MAX_WIDTH : width_r;
  assign h_eff    = (height_r > bmprle_pkg::MAX_HEIGHT) ? bmprle_pkg::MAX_HEIGHT : height_r;
  assign y_bad    = (cy_r >= h_eff);
  assign run_end  = {1'b0, cx_r} + {6'd0, held_r};
  assign lit_end  = {1'b0, cx_r} + {6'd0, data_byte};
  assign dx_sum   = run_end;
  assign dy_sum   = {1'b0, cy_r} + {6'd0, data_byte};
  assign flip_row = h_eff - 13'd1 - cy_r;
  assign lit_len  = (nibble_r && (lit_left_r >= 8'd2)) ? 8'd2 : 8'd1;

  // Decode one byte
  always_comb begin
    phase_nxt    = phase_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    lit_left_nxt = lit_left_r;
    held_nxt     = held_r;
    pad_nxt      = pad_r;
    drain_nxt    = drain_r;
    clear        = 1'b0;
    ent              = '0;
    ent.row          = top_down_r ? cy_r[11:0] : flip_row[11:0];
    ent.column       = cx_r[11:0];
    ent.report_kind  = bmprle_pkg::KIND_DONE;

    if (accept) begin
      if (drain_r) begin
        // drop bytes until the last one
        clear = last_byte;
      end else begin
        case (phase_r)
          bmprle_pkg::PH_CMD0: begin
            held_nxt  = data_byte;
            phase_nxt = bmprle_pkg::PH_CMD1;
          end
          bmprle_pkg::PH_CMD1: begin
            phase_nxt = bmprle_pkg::PH_CMD0;
            if (held_r != 8'd0) begin
              // encoded run
              if (y_bad || (run_end > {1'b0, w_eff})) begin
                ent.has_report  = 1'b1;
                ent.report_kind = bmprle_pkg::KIND_BAD;
              end else begin
                ent.has_span    = 1'b1;
                ent.span_length = held_r;
                if (nibble_r) begin
                  ent.first_value  = {4'd0, data_byte[7:4]};
                  ent.second_value = data_byte & bmprle_pkg::NIB_MASK;
                end else begin
                  ent.first_value  = data_byte;
                  ent.second_value = data_byte;
                end
                cx_nxt = run_end[12:0];
              end
            end else if (data_byte == 8'd0) begin
              // end of line
              if (y_bad) begin
                ent.has_report  = 1'b1;
                ent.report_kind = bmprle_pkg::KIND_BAD;
              end else begin
                cx_nxt = 13'd0;
                cy_nxt = cy_r + 13'd1;
              end
            end else if (data_byte == 8'd1) begin
              // end of bitmap
              ent.has_report  = 1'b1;
              ent.report_kind = bmprle_pkg::KIND_DONE;
            end else if (data_byte == 8'd2) begin
              phase_nxt = bmprle_pkg::PH_DX;
            end else begin
              // absolute run header; 4-bit mode pads when ceil(count/2) is odd
              if (y_bad || (lit_end > {1'b0, w_eff})) begin
                ent.has_report  = 1'b1;
                ent.report_kind = bmprle_pkg::KIND_BAD;
              end else begin
                lit_left_nxt = data_byte;
                pad_nxt      = nibble_r ? (data_byte[1] ^ data_byte[0]) : data_byte[0];
                phase_nxt    = bmprle_pkg::PH_LIT;
              end
            end
          end
          bmprle_pkg::PH_LIT: begin
            ent.has_span    = 1'b1;
            ent.span_length = lit_len;
            if (nibble_r) begin
              ent.first_value  = {4'd0, data_byte[7:4]};
              ent.second_value = (lit_len == 8'd2) ? (data_byte & bmprle_pkg::NIB_MASK) : 8'd0;
            end else begin
              ent.first_value  = data_byte;
              ent.second_value = data_byte;
            end
            cx_nxt       = cx_r + {5'd0, lit_len};
            lit_left_nxt = (lit_left_r > lit_len) ? lit_left_r - lit_len : 8'd0;
            if (lit_left_r <= lit_len) begin
              phase_nxt = pad_r ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_CMD0;
            end
          end
          bmprle_pkg::PH_PAD: begin
            pad_nxt   = 1'b0;
            phase_nxt = bmprle_pkg::PH_CMD0;
          end
          bmprle_pkg::PH_DX: begin
            held_nxt  = data_byte;
            phase_nxt = bmprle_pkg::PH_DY;
          end
          bmprle_pkg::PH_DY: begin
            phase_nxt = bmprle_pkg::PH_CMD0;
            if ((dx_sum >= {1'b0, w_eff}) || (dy_sum >= {1'b0, h_eff})) begin
              ent.has_report  = 1'b1;
              ent.report_kind = bmprle_pkg::KIND_BAD;
            end else begin
              cx_nxt = dx_sum[12:0];
              cy_nxt = dy_sum[12:0];
            end
          end
          default: begin
            phase_nxt = bmprle_pkg::PH_CMD0;
          end
        endcase

        // end of data: clean between commands or not
        if (!ent.has_report && last_byte) begin
          ent.has_report  = 1'b1;
          ent.report_kind = (phase_nxt == bmprle_pkg::PH_CMD0) ? bmprle_pkg::KIND_DONE
                                                               : bmprle_pkg::KIND_BAD;
        end

        if (ent.has_report) begin
          if (last_byte) clear = 1'b1;
          else           drain_nxt = 1'b1;
        end
      end
    end

    // restore the start-of-image state
    if (clear) begin
      phase_nxt    = bmprle_pkg::PH_CMD0;
      cx_nxt       = 13'd0;
      cy_nxt       = 13'd0;
      lit_left_nxt = 8'd0;
      held_nxt     = 8'd0;
      pad_nxt      = 1'b0;
      drain_nxt    = 1'b0;
    end
  end

  assign push       = accept && (ent.has_span || ent.has_report);
  assign push_entry = ent;

  // Advance decoding state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= bmprle_pkg::PH_CMD0;
      cx_r       <= 13'd0;
      cy_r       <= 13'd0;
      lit_left_r <= 8'd0;
      held_r     <= 8'd0;
      pad_r      <= 1'b0;
      drain_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      lit_left_r <= lit_left_nxt;
      held_r     <= held_nxt;
      pad_r      <= pad_nxt;
      drain_r    <= drain_nxt;
    end
  end

endmodule

>>> rtl/core/bmprle_queue.sv
// Short entry queue between the decode front end and the result back end.
`timescale 1ns / 1ps

module bmprle_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bmprle_pkg::entry_t   push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output bmprle_pkg::entry_t   head_entry
);

  bmprle_pkg::entry_t slots_r [bmprle_pkg::QDEPTH];
  logic [bmprle_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bmprle_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bmprle_pkg::QAW:0]   count_r, count_nxt;

  assign full       = (count_r == (bmprle_pkg::QAW+1)'(bmprle_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  // Move pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (bmprle_pkg::QAW+1)'(push) - (bmprle_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

endmodule

>>> rtl/core/bmprle_back.sv
// Back end: splits queue entries into result beats and holds the output register.
`timescale 1ns / 1ps

module bmprle_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  bmprle_pkg::entry_t   head_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [11:0]          out_row,
  output logic [11:0]          out_column,
  output logic [7:0]           out_span_length,
  output logic [7:0]           out_first_value,
  output logic [7:0]           out_second_value
);

  logic        valid_r, valid_nxt;
  logic        sent_span_r, sent_span_nxt;
  logic        load;
  logic        take_span;
  bmprle_pkg::kind_t kind_r;
  logic [11:0] row_r;
  logic [11:0] col_r;
  logic [7:0]  len_r;
  logic [7:0]  v0_r;
  logic [7:0]  v1_r;

  assign load      = !valid_r || out_ready;
  assign take_span = head_entry.has_span && !sent_span_r;

  // Pick the next beat and decide when the head entry is finished
  always_comb begin
    valid_nxt     = valid_r;
    sent_span_nxt = sent_span_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        if (take_span && head_entry.has_report) begin
          sent_span_nxt = 1'b1;
        end else begin
          sent_span_nxt = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      sent_span_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      sent_span_r <= sent_span_nxt;
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (take_span) begin
        kind_r <= bmprle_pkg::KIND_SPAN;
        row_r  <= head_entry.row;
        col_r  <= head_entry.column;
        len_r  <= head_entry.span_length;
        v0_r   <= head_entry.first_value;
        v1_r   <= head_entry.second_value;
      end else begin
        kind_r <= head_entry.report_kind;
        row_r  <= 12'd0;
        col_r  <= 12'd0;
        len_r  <= 8'd0;
        v0_r   <= 8'd0;
        v1_r   <= 8'd0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_row          = row_r;
  assign out_column       = col_r;
  assign out_span_length  = len_r;
  assign out_first_value  = v0_r;
  assign out_second_value = v1_r;

endmodule

>>> rtl/core/bitmap_rle_decoder_core.sv
// Bitmap RLE decoder: 8-bit / 4-bit run-length bytes in, pixel spans and reports out.
// Each result is written into the queue and then loaded into the output register.
// Throughput: one byte per cycle while in_ready is high; one result per cycle while
// out_ready is high; a byte giving a span and a report takes an extra output beat,
// absorbed by the four-entry queue. Reset: synchronous active-low rst_n clears decode
// state, queue and out_valid, and resets config to 8-bit mode, 1x1 image, bottom-up.
`timescale 1ns / 1ps

module bitmap_rle_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  // compressed byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [11:0] out_row,
  output logic [11:0] out_column,
  output logic [7:0]  out_span_length,
  output logic [7:0]  out_first_value,
  output logic [7:0]  out_second_value
);

  logic               accept;
  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  bmprle_pkg::entry_t push_entry;
  bmprle_pkg::entry_t head_entry;

  // Accept a beat while the queue has room
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  bmprle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  bmprle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  bmprle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_span_length  (out_span_length),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

endmodule
